@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ src/bdsl_pkg.sv @@
// Shared types and constants for the button debouncer.
package bdsl_pkg;

	localparam int DEB_W      = 8;
	localparam int AGE_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DEB_W-1:0] DEB_RESET  = 8'd3;
	localparam logic [AGE_W-1:0] LONG_RESET = 16'd120;
	localparam logic [DEB_W-1:0] QUIET_MAX  = '1;
	localparam logic [AGE_W-1:0] AGE_MAX    = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} ev_t;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [AGE_W-1:0] long_ticks;
	} cfg_t;

	typedef struct packed {
		ev_t  ev;
		logic level;
	} result_t;

endpackage

@@ src/button_debounce_short_long_press.sv @@
// Top level: button debouncer with short and long press events.
//
// Input channel: in_valid/in_ready with raw_pressed, one poll tick per transfer.
// Output channel: out_valid/out_ready with press_event (0 none, 1 short,
// 2 long) and debounced_pressed; exactly one result per input tick, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 debounce
// ticks, 1 long-press ticks); other indexes are ignored. Write only while idle.
//
// Path: a tick accepted into the input register is evaluated and stored in the
// output register once that register is empty or being read, and its result
// is offered from there.
// Throughput: one tick per cycle while out_ready is high; the state update is a
// single pass of compare and increment logic between input and output registers.
// When the receiver stalls, the result holds in the output register and one
// more tick is still taken into the input register; after that in_ready drops
// until the result is transferred.
// Reset: thresholds return to 3 and 120 ticks, the button is taken as
// released, counters clear and both pipeline stages empty.
module button_debounce_short_long_press (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            raw_pressed,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      press_event,
	output logic                            debounced_pressed,
	input  logic                            cfg_we,
	input  logic [bdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdsl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdsl_pkg::*;

	cfg_t    cfg;
	result_t res;

	logic valid_s1;
	logic raw_s1;
	logic valid_s2;
	ev_t  ev_s2;
	logic level_s2;
	logic adv;

	bdsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves into the output register when that register is empty or being read
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	bdsl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.raw    (raw_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			raw_s1 <= raw_pressed;
		if (adv) begin
			ev_s2    <= res.ev;
			level_s2 <= res.level;
		end
	end

	assign out_valid         = valid_s2;
	assign press_event       = ev_s2;
	assign debounced_pressed = level_s2;

endmodule

@@ src/bdsl_cfg.sv @@
// Configuration registers: debounce and long-press thresholds.
module bdsl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdsl_pkg::CFG_DATA_W-1:0] cfg_data,
	output bdsl_pkg::cfg_t                  cfg
);
	import bdsl_pkg::*;

	logic [DEB_W-1:0] debounce_q;
	logic [AGE_W-1:0] long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEB_RESET;
			long_q     <= LONG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
				REG_LONG:     long_q     <= cfg_data[AGE_W-1:0];
				default:      ;
			endcase
		end
	end

	assign cfg.debounce_ticks = debounce_q;
	assign cfg.long_ticks     = long_q;

endmodule

@@ src/bdsl_core.sv @@
// Debounce and press-classification state with its one-tick update logic.
module bdsl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              raw,
	input  bdsl_pkg::cfg_t    cfg,
	output bdsl_pkg::result_t res
);
	import bdsl_pkg::*;

	logic             last_raw_q;
	logic [DEB_W-1:0] quiet_q;
	logic             stable_q;
	logic [AGE_W-1:0] age_q;
	logic             long_sent_q;

	logic             changed;
	logic [DEB_W-1:0] quiet_n;
	logic [AGE_W-1:0] age_inc;
	logic [AGE_W-1:0] age_n;
	logic             stable_n;
	logic             long_sent_n;
	logic             trans;
	ev_t              ev_n;

	always_comb begin
		changed = raw != last_raw_q;
		if (changed)
			quiet_n = '0;
		else if (quiet_q != QUIET_MAX)
			quiet_n = quiet_q + 1'b1;
		else
			quiet_n = quiet_q;

		age_inc = (stable_q && age_q != AGE_MAX) ? age_q + 1'b1 : age_q;

		trans       = (quiet_n >= cfg.debounce_ticks) && (raw != stable_q);
		stable_n    = stable_q;
		age_n       = age_inc;
		long_sent_n = long_sent_q;
		ev_n        = EV_NONE;

		if (trans) begin
			stable_n = raw;
			if (raw) begin
				age_n       = '0;
				long_sent_n = 1'b0;
			end else if (!long_sent_q && age_inc < cfg.long_ticks) begin
				ev_n = EV_SHORT;
			end
		end

		// one long event per press, on the tick the age reaches the threshold
		if (stable_n && !long_sent_n && age_n >= cfg.long_ticks) begin
			long_sent_n = 1'b1;
			ev_n        = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b0;
			quiet_q     <= '0;
			stable_q    <= 1'b0;
			age_q       <= '0;
			long_sent_q <= 1'b0;
		end else if (step) begin
			last_raw_q  <= raw;
			quiet_q     <= quiet_n;
			stable_q    <= stable_n;
			age_q       <= age_n;
			long_sent_q <= long_sent_n;
		end
	end

	assign res.ev    = ev_n;
	assign res.level = stable_n;

endmodule

@@ src/bdsl_checker.sv @@
// Port-level checks for the button debouncer, bound to the top level.
`include "assert_macros.svh"

module bdsl_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] press_event,
	input logic       debounced_pressed
);
	import bdsl_pkg::*;

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(press_event) && $stable(debounced_pressed), "stalled result changed")
	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled with empty output")
	`ASSERT_NEVER(a_short_level, clk, arst_n, out_valid && press_event == EV_SHORT && debounced_pressed, "short press while held")
	`ASSERT_NEVER(a_long_level, clk, arst_n, out_valid && press_event == EV_LONG && !debounced_pressed, "long press while released")
	`ASSERT_NEVER(a_bad_event, clk, arst_n, out_valid && press_event != EV_NONE && press_event != EV_SHORT && press_event != EV_LONG, "undefined event code")

endmodule

bind button_debounce_short_long_press bdsl_port_checks u_bdsl_port_checks (.*);
